FILE: rtl/incremental_triangle_counter_unit_macros.svh
// Assertion macros shared by the triangle counter.
`ifndef INCREMENTAL_TRIANGLE_COUNTER_UNIT_MACROS_SVH
`define INCREMENTAL_TRIANGLE_COUNTER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ITC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ITC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/itc_pkg.sv
package itc_pkg;

    localparam int NODE_W   = 6;
    localparam int OP_W     = 2;
    localparam int COMMON_W = 6;
    localparam int COUNT_W  = 11;
    localparam int TOTAL_W  = 16;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

    localparam logic STATUS_DONE     = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_COMMIT = 5'b01000,
        ST_RESP   = 5'b10000
    } state_t;

    // Broadcast to every cell while an edge update is applied.
    typedef struct packed {
        logic                commit;
        logic                insert;
        logic [COMMON_W-1:0] common;
    } cell_ctrl_t;

endpackage

FILE: rtl/itc_cell.sv
module itc_cell #(
    parameter int NODES = 64,
    parameter int IDX   = 0,
    parameter int IDX_W = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  itc_pkg::cell_ctrl_t                 ctrl,
    input  logic [IDX_W-1:0]                    a_idx,
    input  logic [IDX_W-1:0]                    b_idx,
    input  logic [itc_pkg::COMMON_W-1:0]        psum_in,
    output logic [itc_pkg::COMMON_W-1:0]        psum_out,
    output logic                                sel_bit,
    output logic [itc_pkg::COUNT_W-1:0]         sel_count
);

    logic [NODES-1:0]                 row_reg;
    logic [itc_pkg::COUNT_W-1:0]      count_reg;
    logic [itc_pkg::COMMON_W-1:0]     psum_reg;
    logic                             is_a;
    logic                             is_b;
    logic                             hit;

    assign is_a = (a_idx == IDX_W'(IDX));
    assign is_b = (b_idx == IDX_W'(IDX));

    // By symmetry this node is a common neighbor of a and b when its own row
    // holds both a and b. Its own row never holds itself, so endpoints miss.
    assign hit = row_reg[a_idx] & row_reg[b_idx];

    assign psum_out  = psum_reg;
    assign sel_bit   = is_a & row_reg[b_idx];
    assign sel_count = is_a ? count_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            count_reg <= '0;
            psum_reg  <= '0;
        end
        else
        begin
            psum_reg <= psum_in + itc_pkg::COMMON_W'(hit);
            if (ctrl.commit)
            begin
                if (is_a)
                begin
                    row_reg[b_idx] <= ctrl.insert;
                    count_reg <= ctrl.insert
                        ? count_reg + itc_pkg::COUNT_W'(ctrl.common)
                        : count_reg - itc_pkg::COUNT_W'(ctrl.common);
                end
                else if (is_b)
                begin
                    row_reg[a_idx] <= ctrl.insert;
                    count_reg <= ctrl.insert
                        ? count_reg + itc_pkg::COUNT_W'(ctrl.common)
                        : count_reg - itc_pkg::COUNT_W'(ctrl.common);
                end
                else if (hit)
                begin
                    count_reg <= ctrl.insert ? count_reg + 1'b1 : count_reg - 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/incremental_triangle_counter_unit.sv
// Channel   Handshake          Payload
// command   start / busy       op, node_a, node_b
// result    done (one cycle)   status, common_count, total_triangles, node_triangles
//
// A query or a rejected item passes through the check state and then gives its result.
// An accepted edge update passes through the check, sweep and commit states: the common-neighbor count
// ripples through the chain of node cells, one cell per cycle.
// Reset empties the graph and clears the triangle counts at once.
// The result is shown for one cycle with done; the receiver cannot stall it.
module incremental_triangle_counter_unit #(
    parameter int NODES = 64
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [itc_pkg::OP_W-1:0]           op,
    input  logic [itc_pkg::NODE_W-1:0]         node_a,
    input  logic [itc_pkg::NODE_W-1:0]         node_b,
    output logic                               done,
    output logic                               status,
    output logic [itc_pkg::COMMON_W-1:0]       common_count,
    output logic [itc_pkg::TOTAL_W-1:0]        total_triangles,
    output logic [itc_pkg::COUNT_W-1:0]        node_triangles
);

`include "incremental_triangle_counter_unit_macros.svh"

    localparam int IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = $clog2(NODES + 1);

    itc_pkg::state_t                    state_reg, state_next;
    logic [itc_pkg::OP_W-1:0]           op_reg;
    logic [itc_pkg::NODE_W-1:0]         a_reg;
    logic [itc_pkg::NODE_W-1:0]         b_reg;
    logic                               status_reg;
    logic [itc_pkg::COMMON_W-1:0]       common_reg;
    logic [itc_pkg::TOTAL_W-1:0]        total_reg;
    logic [CNT_W-1:0]                   sweep_reg;

    logic [IDX_W-1:0]                   a_idx;
    logic [IDX_W-1:0]                   b_idx;
    logic                               a_ok;
    logic                               b_ok;
    logic                               present;
    logic                               reject;
    logic [itc_pkg::COUNT_W-1:0]        a_count;
    itc_pkg::cell_ctrl_t                ctrl;

    logic [itc_pkg::COMMON_W-1:0]       psum [NODES+1];
    logic [NODES-1:0]                   sel_bits;
    logic [itc_pkg::COUNT_W-1:0]        sel_counts [NODES];

    assign a_idx = IDX_W'(a_reg);
    assign b_idx = IDX_W'(b_reg);
    assign a_ok  = (32'(a_reg) < NODES);
    assign b_ok  = (32'(b_reg) < NODES);

    assign psum[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < NODES; gi++)
        begin : g_cell
            itc_cell #(
                .NODES (NODES),
                .IDX   (gi),
                .IDX_W (IDX_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .a_idx     (a_idx),
                .b_idx     (b_idx),
                .psum_in   (psum[gi]),
                .psum_out  (psum[gi+1]),
                .sel_bit   (sel_bits[gi]),
                .sel_count (sel_counts[gi])
            );
        end
    endgenerate

    // Only the cell of node a drives its selected bit and count.
    always_comb
    begin
        a_count = '0;
        for (int i = 0; i < NODES; i++)
        begin
            a_count = a_count | sel_counts[i];
        end
    end

    assign present = a_ok & |sel_bits;

    always_comb
    begin
        reject = 1'b0;
        if (op_reg != itc_pkg::OP_INSERT && op_reg != itc_pkg::OP_REMOVE)
            reject = 1'b1;
        else if (!a_ok || !b_ok || a_reg == b_reg)
            reject = 1'b1;
        else if (op_reg == itc_pkg::OP_INSERT && present)
            reject = 1'b1;
        else if (op_reg == itc_pkg::OP_REMOVE && !present)
            reject = 1'b1;
    end

    assign ctrl.commit = (state_reg == itc_pkg::ST_COMMIT);
    assign ctrl.insert = (op_reg == itc_pkg::OP_INSERT);
    assign ctrl.common = psum[NODES];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            itc_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = itc_pkg::ST_CHECK;
            end
            itc_pkg::ST_CHECK:
            begin
                if (op_reg == itc_pkg::OP_QUERY || reject)
                    state_next = itc_pkg::ST_RESP;
                else
                    state_next = itc_pkg::ST_SWEEP;
            end
            itc_pkg::ST_SWEEP:
            begin
                if (sweep_reg == CNT_W'(NODES - 1))
                    state_next = itc_pkg::ST_COMMIT;
            end
            itc_pkg::ST_COMMIT:
            begin
                state_next = itc_pkg::ST_RESP;
            end
            itc_pkg::ST_RESP:
            begin
                state_next = itc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = itc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= itc_pkg::ST_IDLE;
            total_reg <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == itc_pkg::ST_CHECK)
                sweep_reg <= '0;
            else if (state_reg == itc_pkg::ST_SWEEP)
                sweep_reg <= sweep_reg + 1'b1;
            if (ctrl.commit)
            begin
                total_reg <= ctrl.insert
                    ? total_reg + itc_pkg::TOTAL_W'(ctrl.common)
                    : total_reg - itc_pkg::TOTAL_W'(ctrl.common);
            end
        end
    end

    // The transaction's payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (state_reg == itc_pkg::ST_IDLE && start)
        begin
            op_reg <= op;
            a_reg  <= node_a;
            b_reg  <= node_b;
        end
        if (state_reg == itc_pkg::ST_CHECK)
        begin
            common_reg <= '0;
            if (op_reg == itc_pkg::OP_QUERY)
                status_reg <= a_ok ? itc_pkg::STATUS_DONE : itc_pkg::STATUS_REJECTED;
            else
                status_reg <= reject ? itc_pkg::STATUS_REJECTED : itc_pkg::STATUS_DONE;
        end
        if (ctrl.commit)
            common_reg <= ctrl.common;
    end

    assign busy            = (state_reg != itc_pkg::ST_IDLE);
    assign done            = (state_reg == itc_pkg::ST_RESP);
    assign status          = status_reg;
    assign common_count    = common_reg;
    assign total_triangles = total_reg;
    // A node outside the graph would alias onto a cell through the narrow index.
    assign node_triangles  = a_ok ? a_count : '0;

    `ITC_ASSERT_NEXT(a_accept_busy, start && !busy, busy,
        "accepted transaction did not make the unit busy")
    `ITC_ASSERT_NEXT(a_done_idle, done, !busy,
        "unit still busy after delivering a result")
    `ITC_ASSERT_NOW(a_reject_zero, done && status == itc_pkg::STATUS_REJECTED,
        common_count == '0, "rejected transaction reported common neighbors")
    `ITC_ASSERT_NOW(a_total_commit, !$stable(total_reg),
        $past(state_reg) == itc_pkg::ST_COMMIT,
        "total triangle count changed outside an edge update")

endmodule

FILE: dv/tb_incremental_triangle_counter_unit.sv
module tb_incremental_triangle_counter_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES         = 64;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int STALL_LIMIT   = 1000;
    localparam int DRAIN_CYCLES  = NODES + 8;
    localparam int DIRECTED_ROWS = 24;

    // The one op code the block does not define.
    localparam logic [itc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                         status;
        logic [itc_pkg::COMMON_W-1:0] common;
        logic [itc_pkg::TOTAL_W-1:0]  total;
        logic [itc_pkg::COUNT_W-1:0]  node_cnt;
    } tri_result_t;

    typedef struct {
        logic [itc_pkg::OP_W-1:0]   op;
        logic [itc_pkg::NODE_W-1:0] a;
        logic [itc_pkg::NODE_W-1:0] b;
        bit                         typed;
        tri_result_t                res;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [itc_pkg::OP_W-1:0]     op;
    logic [itc_pkg::NODE_W-1:0]   node_a;
    logic [itc_pkg::NODE_W-1:0]   node_b;
    logic                         done;
    logic                         status;
    logic [itc_pkg::COMMON_W-1:0] common_count;
    logic [itc_pkg::TOTAL_W-1:0]  total_triangles;
    logic [itc_pkg::COUNT_W-1:0]  node_triangles;

    // Expectation typed into the directed table, carried along with the transaction.
    bit                  typed_valid;
    tri_result_t         typed_result;

    // Predictor state: adjacency, per-node triangle counts and the graph total.
    logic [NODES-1:0]    graph_adj [NODES];
    int                  node_tri [NODES];
    int                  total_tri;

    // Edge set as seen by the stimulus side, used to pick removals.
    logic [NODES-1:0]    stim_adj [NODES];

    tri_result_t         pending_results [$];
    tri_result_t         oldest_result;
    tri_result_t         predicted_result;
    int                  mismatch_count;
    int                  stall_cycles;
    stim_row_t           directed_rows [DIRECTED_ROWS];

    incremental_triangle_counter_unit #(
        .NODES(NODES)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .node_a          (node_a),
        .node_b          (node_b),
        .done            (done),
        .status          (status),
        .common_count    (common_count),
        .total_triangles (total_triangles),
        .node_triangles  (node_triangles)
    );

    always #10ns clk = ~clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic tri_result_t apply_graph_item(input logic [itc_pkg::OP_W-1:0] o,
                                                     input logic [itc_pkg::NODE_W-1:0] a,
                                                     input logic [itc_pkg::NODE_W-1:0] b);
        tri_result_t r;
        int          common;
        int          step;
        logic        present;
        common   = 0;
        present  = graph_adj[a][b];
        r.status = itc_pkg::STATUS_REJECTED;
        r.common = '0;
        if (o == itc_pkg::OP_QUERY)
        begin
            r.status = itc_pkg::STATUS_DONE;
        end
        else if (a != b && ((o == itc_pkg::OP_INSERT && !present) ||
                            (o == itc_pkg::OP_REMOVE && present)))
        begin
            step = (o == itc_pkg::OP_INSERT) ? 1 : -1;
            for (int c = 0; c < NODES; c++)
            begin
                if (c != a && c != b && graph_adj[a][c] && graph_adj[b][c])
                begin
                    common++;
                    node_tri[c] += step;
                end
            end
            graph_adj[a][b] = (o == itc_pkg::OP_INSERT);
            graph_adj[b][a] = (o == itc_pkg::OP_INSERT);
            node_tri[a] += step * common;
            node_tri[b] += step * common;
            total_tri   += step * common;
            r.status = itc_pkg::STATUS_DONE;
            r.common = common[itc_pkg::COMMON_W-1:0];
        end
        r.total    = total_tri[itc_pkg::TOTAL_W-1:0];
        r.node_cnt = node_tri[a][itc_pkg::COUNT_W-1:0];
        return r;
    endfunction

    function automatic stim_row_t row(input logic [itc_pkg::OP_W-1:0] o, input int a,
                                      input int b, input bit typed = 1'b0,
                                      input logic st = itc_pkg::STATUS_DONE,
                                      input int common = 0, input int total = 0,
                                      input int node_cnt = 0);
        stim_row_t s;
        s.op         = o;
        s.a          = a[itc_pkg::NODE_W-1:0];
        s.b          = b[itc_pkg::NODE_W-1:0];
        s.typed      = typed;
        s.res.status = st;
        s.res.common = common[itc_pkg::COMMON_W-1:0];
        s.res.total  = total[itc_pkg::TOTAL_W-1:0];
        s.res.node_cnt = node_cnt[itc_pkg::COUNT_W-1:0];
        return s;
    endfunction

    // Result checking and prediction share one process, so a result and an
    // acceptance on the same edge are always handled in the same order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with nothing pending, status", status, 0);
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (status !== oldest_result.status)
                        report_mismatch("status", status, oldest_result.status);
                    if (common_count !== oldest_result.common)
                        report_mismatch("common_count", common_count, oldest_result.common);
                    if (total_triangles !== oldest_result.total)
                        report_mismatch("total_triangles", total_triangles, oldest_result.total);
                    if (node_triangles !== oldest_result.node_cnt)
                        report_mismatch("node_triangles", node_triangles,
                                        oldest_result.node_cnt);
                end
            end
            if (start && !busy)
            begin
                predicted_result = apply_graph_item(op, node_a, node_b);
                pending_results = {pending_results,
                                   (typed_valid ? typed_result : predicted_result)};
            end
            if ((start && !busy) || done)
            begin
                stall_cycles <= 0;
            end
            else if (stall_cycles + 1 >= STALL_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
            else
            begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    task automatic send_graph_cmd(input logic [itc_pkg::OP_W-1:0] o,
                                  input logic [itc_pkg::NODE_W-1:0] a,
                                  input logic [itc_pkg::NODE_W-1:0] b,
                                  input bit typed = 1'b0,
                                  input tri_result_t typed_res = '0);
        start        <= 1'b1;
        op           <= o;
        node_a       <= a;
        node_b       <= b;
        typed_valid  <= typed;
        typed_result <= typed_res;
        @(posedge clk);
        while (busy) @(posedge clk);
        if (a != b && o == itc_pkg::OP_INSERT)
        begin
            stim_adj[a][b] = 1'b1;
            stim_adj[b][a] = 1'b1;
        end
        else if (a != b && o == itc_pkg::OP_REMOVE)
        begin
            stim_adj[a][b] = 1'b0;
            stim_adj[b][a] = 1'b0;
        end
    endtask

    task automatic sender_pause(input bit quiet);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 14)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 4);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int                         win_size;
        int                         win_base;
        int                         grow_pct;
        int                         pick;
        int                         a;
        int                         b;
        logic [itc_pkg::OP_W-1:0]   o;

        for (int n = 0; n < NODES; n++)
        begin
            graph_adj[n] = '0;
            stim_adj[n]  = '0;
            node_tri[n]  = 0;
        end
        total_tri      = 0;
        mismatch_count = 0;
        stall_cycles   = 0;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        op             <= itc_pkg::OP_QUERY;
        node_a         <= '0;
        node_b         <= '0;
        typed_valid    <= 1'b0;
        typed_result   <= '0;

        directed_rows[0]  = row(itc_pkg::OP_QUERY,  0,  0, 1, itc_pkg::STATUS_DONE);
        directed_rows[1]  = row(itc_pkg::OP_QUERY, 63, 63, 1, itc_pkg::STATUS_DONE);
        directed_rows[2]  = row(itc_pkg::OP_INSERT, 5,  5, 1, itc_pkg::STATUS_REJECTED);
        directed_rows[3]  = row(itc_pkg::OP_REMOVE, 1,  2, 1, itc_pkg::STATUS_REJECTED);
        directed_rows[4]  = row(OP_UNUSED,         63, 63, 1, itc_pkg::STATUS_REJECTED);
        directed_rows[5]  = row(itc_pkg::OP_INSERT, 0,  1, 1, itc_pkg::STATUS_DONE);
        directed_rows[6]  = row(itc_pkg::OP_INSERT, 1,  2, 1, itc_pkg::STATUS_DONE);
        directed_rows[7]  = row(itc_pkg::OP_INSERT, 2,  0, 1, itc_pkg::STATUS_DONE, 1, 1, 1);
        directed_rows[8]  = row(itc_pkg::OP_INSERT, 0,  1, 1, itc_pkg::STATUS_REJECTED,
                                0, 1, 1);
        directed_rows[9]  = row(itc_pkg::OP_REMOVE, 63, 0, 1, itc_pkg::STATUS_REJECTED,
                                0, 1, 0);
        directed_rows[10] = row(itc_pkg::OP_INSERT, 63, 0);
        directed_rows[11] = row(itc_pkg::OP_INSERT, 63, 1);
        directed_rows[12] = row(itc_pkg::OP_INSERT, 63, 2);
        directed_rows[13] = row(itc_pkg::OP_QUERY,  63, 17);
        directed_rows[14] = row(OP_UNUSED,           0, 63);
        directed_rows[15] = row(itc_pkg::OP_REMOVE,  0, 1);
        directed_rows[16] = row(itc_pkg::OP_REMOVE,  1, 0);
        directed_rows[17] = row(itc_pkg::OP_INSERT, 62, 63);
        directed_rows[18] = row(itc_pkg::OP_INSERT, 62, 0);
        directed_rows[19] = row(itc_pkg::OP_INSERT, 62, 2);
        directed_rows[20] = row(itc_pkg::OP_REMOVE, 63, 2);
        directed_rows[21] = row(itc_pkg::OP_QUERY,   2, 0);
        directed_rows[22] = row(itc_pkg::OP_REMOVE,  2, 2);
        directed_rows[23] = row(OP_UNUSED,           0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_graph_cmd(directed_rows[i].op, directed_rows[i].a, directed_rows[i].b,
                           directed_rows[i].typed, directed_rows[i].res);
            sender_pause(1'b0);
        end

        win_size = NODES;
        win_base = 0;
        grow_pct = 45;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Each phase draws its inserts and removals from a window of nodes, so small windows get dense
            // quickly and the full window builds up large totals.
            if (i % 250 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: win_size = 6;
                    1: win_size = 12;
                    2: win_size = 24;
                    default: win_size = NODES;
                endcase
                win_base = $urandom_range(0, NODES - win_size);
                grow_pct = ($urandom_range(0, 2) == 0) ? 15 : 50;
            end
            pick = $urandom_range(0, 99);
            a = win_base + $urandom_range(0, win_size - 1);
            b = win_base + (a - win_base + $urandom_range(1, win_size - 1)) % win_size;
            if (pick < grow_pct)
            begin
                o = itc_pkg::OP_INSERT;
            end
            else if (pick < grow_pct + 25)
            begin
                o = itc_pkg::OP_REMOVE;
                for (int t = 0; t < 8 && !stim_adj[a][b]; t++)
                begin
                    a = win_base + $urandom_range(0, win_size - 1);
                    b = win_base + (a - win_base + $urandom_range(1, win_size - 1)) % win_size;
                end
            end
            else if (pick < grow_pct + 40)
            begin
                o = itc_pkg::OP_QUERY;
                a = $urandom_range(0, NODES - 1);
                b = $urandom_range(0, NODES - 1);
            end
            else
            begin
                a = $urandom_range(0, NODES - 1);
                b = $urandom_range(0, NODES - 1);
                case ($urandom_range(0, 2))
                    0:
                    begin
                        o = $urandom_range(0, 1) ? itc_pkg::OP_INSERT : itc_pkg::OP_REMOVE;
                        b = a;
                    end
                    1: o = OP_UNUSED;
                    default: o = $urandom_range(0, 1) ? itc_pkg::OP_INSERT
                                                      : itc_pkg::OP_REMOVE;
                endcase
            end
            send_graph_cmd(o, a[itc_pkg::NODE_W-1:0], b[itc_pkg::NODE_W-1:0]);
            sender_pause(i >= 800 && i < 1200);
        end
        start <= 1'b0;

        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());
        if (mismatch_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
